@@ rtl/asc_pkg.sv @@
// ----------------------------------------------------------------------------
// asc_pkg
// Shared constants for the affine sample coordinate mapper: register
// indexes, edge modes and fixed-point limits.
// ----------------------------------------------------------------------------
package asc_pkg;

	// default coordinate width (Q20.12)
	localparam int COORD_WIDTH_DEF = 32;

	// configuration port geometry
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ROTATION    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BOUNDS_LOW  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BOUNDS_HIGH = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_EDGE_MODE   = 3'd5;

	// edge modes
	localparam logic [1:0] MODE_ZERO   = 2'd0;
	localparam logic [1:0] MODE_CLAMP  = 2'd1;
	localparam logic [1:0] MODE_MIRROR = 2'd2;

	// Q1.14 unity and Q16.16 scale floor (0.001 rounded up)
	localparam logic signed [15:0] TRIG_ONE    = 16'sd16384;
	localparam logic [31:0]        SCALE_FLOOR = 32'd66;

	// register reset values
	localparam logic [31:0] ROTATION_RST = 32'h0000_4000;
	localparam logic [63:0] SCALE_RST    = 64'h0001_0000_0001_0000;

endpackage

@@ rtl/asc_in_if.sv @@
// ----------------------------------------------------------------------------
// asc_in_if
// Destination position channel: valid/ready with one coordinate pair.
// ----------------------------------------------------------------------------
interface asc_in_if #(
	parameter int COORD_WIDTH = asc_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] dest_x;
	logic signed [COORD_WIDTH-1:0] dest_y;

	modport source(output valid, dest_x, dest_y, input ready);
	modport sink(input valid, dest_x, dest_y, output ready);
endinterface

@@ rtl/asc_out_if.sv @@
// ----------------------------------------------------------------------------
// asc_out_if
// Source position channel: valid/ready with coordinate pair and outside flag.
// ----------------------------------------------------------------------------
interface asc_out_if #(
	parameter int COORD_WIDTH = asc_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] src_x;
	logic signed [COORD_WIDTH-1:0] src_y;
	logic                          outside;

	modport source(output valid, src_x, src_y, outside, input ready);
	modport sink(input valid, src_x, src_y, outside, output ready);
endinterface

@@ rtl/asc_cfg.sv @@
// ----------------------------------------------------------------------------
// asc_cfg
// Configuration registers and the values derived from them: saturated
// bounds and offset, center, fold period, clamped trig and floored scale.
// ----------------------------------------------------------------------------
module asc_cfg #(
	parameter int COORD_WIDTH = asc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [asc_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [asc_pkg::CFG_DATA_W-1:0]      wr_data,
	output logic signed [COORD_WIDTH-1:0]       min_x,
	output logic signed [COORD_WIDTH-1:0]       min_y,
	output logic signed [COORD_WIDTH-1:0]       max_x,
	output logic signed [COORD_WIDTH-1:0]       max_y,
	output logic signed [COORD_WIDTH-1:0]       off_x,
	output logic signed [COORD_WIDTH-1:0]       off_y,
	output logic signed [COORD_WIDTH-1:0]       cen_x,
	output logic signed [COORD_WIDTH-1:0]       cen_y,
	output logic [COORD_WIDTH-1:0]              rng_x,
	output logic [COORD_WIDTH-1:0]              rng_y,
	output logic                                rng_pos_x,
	output logic                                rng_pos_y,
	output logic [COORD_WIDTH:0]                per_x,
	output logic [COORD_WIDTH:0]                per_y,
	output logic signed [15:0]                  cos_v,
	output logic signed [15:0]                  sin_v,
	output logic [31:0]                         scl_x,
	output logic [31:0]                         scl_y,
	output logic [1:0]                          mode
);
	localparam int W  = COORD_WIDTH;
	localparam int EW = (W > 32) ? W : 32;
	localparam logic signed [EW:0] CMAXE = {{(EW-W+2){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [EW:0] CMINE = {{(EW-W+2){1'b1}}, {(W-1){1'b0}}};

	logic [31:0] rotation_q;
	logic [63:0] scale_q;
	logic [63:0] offset_q;
	logic [63:0] low_q;
	logic [63:0] high_q;
	logic [1:0]  mode_q;

	logic signed [W:0]  sum_x, sum_y, dif_x, dif_y;
	logic signed [15:0] cos_raw, sin_raw;

	// saturate a 32-bit register half to the coordinate range
	function automatic logic signed [W-1:0] sat_half(input logic signed [31:0] h);
		logic signed [EW:0] e;
		e = (EW+1)'(h);
		if (e > CMAXE) begin
			return CMAXE[W-1:0];
		end else if (e < CMINE) begin
			return CMINE[W-1:0];
		end
		return e[W-1:0];
	endfunction

	// clamp a Q1.14 value to +-1.0
	function automatic logic signed [15:0] clamp_trig(input logic signed [15:0] t);
		if (t > asc_pkg::TRIG_ONE) begin
			return asc_pkg::TRIG_ONE;
		end else if (t < -asc_pkg::TRIG_ONE) begin
			return -asc_pkg::TRIG_ONE;
		end
		return t;
	endfunction

	// write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= asc_pkg::ROTATION_RST;
			scale_q    <= asc_pkg::SCALE_RST;
			offset_q   <= '0;
			low_q      <= '0;
			high_q     <= '0;
			mode_q     <= asc_pkg::MODE_ZERO;
		end else if (wr_en) begin
			case (wr_index)
				asc_pkg::REG_ROTATION:    rotation_q <= wr_data[31:0];
				asc_pkg::REG_SCALE:       scale_q    <= wr_data;
				asc_pkg::REG_OFFSET:      offset_q   <= wr_data;
				asc_pkg::REG_BOUNDS_LOW:  low_q      <= wr_data;
				asc_pkg::REG_BOUNDS_HIGH: high_q     <= wr_data;
				asc_pkg::REG_EDGE_MODE:   mode_q     <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	// derive the per-axis constants
	always_comb begin
		min_x = sat_half(low_q[31:0]);
		min_y = sat_half(low_q[63:32]);
		max_x = sat_half(high_q[31:0]);
		max_y = sat_half(high_q[63:32]);
		off_x = sat_half(offset_q[31:0]);
		off_y = sat_half(offset_q[63:32]);

		sum_x = (W+1)'(min_x) + (W+1)'(max_x);
		sum_y = (W+1)'(min_y) + (W+1)'(max_y);
		cen_x = sum_x[W:1];
		cen_y = sum_y[W:1];

		dif_x = (W+1)'(max_x) - (W+1)'(min_x);
		dif_y = (W+1)'(max_y) - (W+1)'(min_y);
		rng_pos_x = (dif_x > 0);
		rng_pos_y = (dif_y > 0);
		rng_x = dif_x[W-1:0];
		rng_y = dif_y[W-1:0];
		per_x = {dif_x[W-1:0], 1'b0};
		per_y = {dif_y[W-1:0], 1'b0};

		cos_raw = rotation_q[15:0];
		sin_raw = rotation_q[31:16];
		cos_v = clamp_trig(cos_raw);
		sin_v = clamp_trig(sin_raw);

		scl_x = (scale_q[31:0] < asc_pkg::SCALE_FLOOR) ? asc_pkg::SCALE_FLOOR : scale_q[31:0];
		scl_y = (scale_q[63:32] < asc_pkg::SCALE_FLOOR) ? asc_pkg::SCALE_FLOOR
		                                                : scale_q[63:32];
		mode = mode_q;
	end
endmodule

@@ rtl/asc_front.sv @@
// ----------------------------------------------------------------------------
// asc_front
// Shift by center and offset, rotate, and form the dividend magnitudes
// (times four) for the per-axis scale division. Three register stages.
// ----------------------------------------------------------------------------
module asc_front #(
	parameter int COORD_WIDTH = asc_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] dest_x,
	input  logic signed [COORD_WIDTH-1:0] dest_y,
	input  logic signed [COORD_WIDTH-1:0] cen_x,
	input  logic signed [COORD_WIDTH-1:0] cen_y,
	input  logic signed [COORD_WIDTH-1:0] off_x,
	input  logic signed [COORD_WIDTH-1:0] off_y,
	input  logic signed [15:0]            cos_v,
	input  logic signed [15:0]            sin_v,
	output logic                          valid_s3,
	output logic [COORD_WIDTH+16:0]       mag_x_s3,
	output logic [COORD_WIDTH+16:0]       mag_y_s3,
	output logic                          neg_x_s3,
	output logic                          neg_y_s3
);
	localparam int W  = COORD_WIDTH;
	localparam int PW = W + 16;
	localparam int RW = W + 17;
	localparam logic signed [W+1:0] SMAX = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [W+1:0] SMIN = {3'b111, {(W-1){1'b0}}};

	logic                  valid_s1, valid_s2;
	logic signed [W-1:0]   sh_x_s1, sh_y_s1;
	logic signed [PW-1:0]  pxc_s2, pys_s2, pyc_s2, pxs_s2;
	logic signed [W+1:0]   sw_x, sw_y;
	logic signed [RW-1:0]  r_x, r_y;
	logic [RW-1:0]         m_x, m_y;

	// shift into centered frame, saturate
	always_comb begin
		sw_x = (W+2)'(dest_x) - (W+2)'(cen_x) - (W+2)'(off_x);
		sw_y = (W+2)'(dest_y) - (W+2)'(cen_y) - (W+2)'(off_y);
		r_x  = RW'(pxc_s2) + RW'(pys_s2);
		r_y  = RW'(pyc_s2) - RW'(pxs_s2);
		m_x  = r_x[RW-1] ? RW'(-r_x) : RW'(r_x);
		m_y  = r_y[RW-1] ? RW'(-r_y) : RW'(r_y);
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			sh_x_s1 <= (sw_x > SMAX) ? SMAX[W-1:0] : (sw_x < SMIN) ? SMIN[W-1:0] : sw_x[W-1:0];
			sh_y_s1 <= (sw_y > SMAX) ? SMAX[W-1:0] : (sw_y < SMIN) ? SMIN[W-1:0] : sw_y[W-1:0];
			pxc_s2  <= PW'(cos_v) * PW'(sh_x_s1);
			pys_s2  <= PW'(sin_v) * PW'(sh_y_s1);
			pyc_s2  <= PW'(cos_v) * PW'(sh_y_s1);
			pxs_s2  <= PW'(sin_v) * PW'(sh_x_s1);
			mag_x_s3 <= {m_x[RW-3:0], 2'b00};
			mag_y_s3 <= {m_y[RW-3:0], 2'b00};
			neg_x_s3 <= r_x[RW-1];
			neg_y_s3 <= r_y[RW-1];
		end
	end
endmodule

@@ rtl/asc_div.sv @@
// ----------------------------------------------------------------------------
// asc_div
// Pipelined restoring divider, one quotient bit per stage. The divisor is
// held steady by the caller while items are in flight; a sideband word
// travels with each item.
// ----------------------------------------------------------------------------
module asc_div #(
	parameter int NUM_W  = 49,
	parameter int DIV_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DIV_W-1:0]  divisor,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output logic [DIV_W-1:0]  out_rem,
	output logic [SIDE_W-1:0] out_side
);
	logic              vld_s  [1:NUM_W];
	logic [NUM_W-1:0]  num_s  [1:NUM_W];
	logic [DIV_W-1:0]  rem_s  [1:NUM_W];
	logic [SIDE_W-1:0] side_s [1:NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic              v_in;
		logic [NUM_W-1:0]  n_in;
		logic [DIV_W-1:0]  r_in;
		logic [SIDE_W-1:0] sd_in;
		logic [DIV_W:0]    trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign n_in  = in_num;
			assign r_in  = '0;
			assign sd_in = in_side;
		end else begin : g_next
			assign v_in  = vld_s[k];
			assign n_in  = num_s[k];
			assign r_in  = rem_s[k];
			assign sd_in = side_s[k];
		end

		// bring down the next dividend bit and try the subtraction
		assign trial = {r_in, n_in[NUM_W-1]};
		assign ge    = (trial >= {1'b0, divisor});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
				num_s[k+1]  <= {n_in[NUM_W-2:0], ge};
				side_s[k+1] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign out_quo   = num_s[NUM_W];
	assign out_rem   = rem_s[NUM_W];
	assign out_side  = side_s[NUM_W];
endmodule

@@ rtl/asc_place.sv @@
// ----------------------------------------------------------------------------
// asc_place
// Add the signed scaled delta back to the center with saturation, then test
// the bounds, form the clamped value and prepare the fold dividend.
// ----------------------------------------------------------------------------
module asc_place #(
	parameter int COORD_WIDTH = asc_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [COORD_WIDTH+16:0]       quo_x,
	input  logic [COORD_WIDTH+16:0]       quo_y,
	input  logic                          neg_x,
	input  logic                          neg_y,
	input  logic signed [COORD_WIDTH-1:0] cen_x,
	input  logic signed [COORD_WIDTH-1:0] cen_y,
	input  logic signed [COORD_WIDTH-1:0] min_x,
	input  logic signed [COORD_WIDTH-1:0] min_y,
	input  logic signed [COORD_WIDTH-1:0] max_x,
	input  logic signed [COORD_WIDTH-1:0] max_y,
	output logic                          valid_s5,
	output logic                          out_any_s5,
	output logic [COORD_WIDTH-1:0]        abs_x_s5,
	output logic [COORD_WIDTH-1:0]        abs_y_s5,
	output logic                          tneg_x_s5,
	output logic                          tneg_y_s5,
	output logic signed [COORD_WIDTH-1:0] sel_x_s5,
	output logic signed [COORD_WIDTH-1:0] sel_y_s5
);
	localparam int W  = COORD_WIDTH;
	localparam int XW = W + 19;
	localparam logic signed [XW-1:0] VMAX = {{20{1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] VMIN = {{20{1'b1}}, {(W-1){1'b0}}};

	logic                 valid_s4;
	logic signed [W-1:0]  v_x_s4, v_y_s4;
	logic signed [XW-1:0] d_x, d_y, s_x, s_y;
	logic signed [W:0]    t_x, t_y;
	logic                 any;

	always_comb begin
		// signed delta plus center
		d_x = neg_x ? -$signed({2'b00, quo_x}) : $signed({2'b00, quo_x});
		d_y = neg_y ? -$signed({2'b00, quo_y}) : $signed({2'b00, quo_y});
		s_x = XW'(cen_x) + d_x;
		s_y = XW'(cen_y) + d_y;

		// bounds test and fold offset
		any = (v_x_s4 < min_x) || (v_x_s4 > max_x) || (v_y_s4 < min_y) || (v_y_s4 > max_y);
		t_x = (W+1)'(v_x_s4) - (W+1)'(min_x);
		t_y = (W+1)'(v_y_s4) - (W+1)'(min_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_x_s4 <= (s_x > VMAX) ? VMAX[W-1:0] : (s_x < VMIN) ? VMIN[W-1:0] : s_x[W-1:0];
			v_y_s4 <= (s_y > VMAX) ? VMAX[W-1:0] : (s_y < VMIN) ? VMIN[W-1:0] : s_y[W-1:0];

			out_any_s5 <= any;
			tneg_x_s5  <= t_x[W];
			tneg_y_s5  <= t_y[W];
			abs_x_s5   <= t_x[W] ? W'(-t_x) : t_x[W-1:0];
			abs_y_s5   <= t_y[W] ? W'(-t_y) : t_y[W-1:0];
			// inside keeps the value; outside takes the clamped one
			if (!any) begin
				sel_x_s5 <= v_x_s4;
				sel_y_s5 <= v_y_s4;
			end else begin
				sel_x_s5 <= (v_x_s4 < min_x) ? min_x : (v_x_s4 < max_x) ? v_x_s4 : max_x;
				sel_y_s5 <= (v_y_s4 < min_y) ? min_y : (v_y_s4 < max_y) ? v_y_s4 : max_y;
			end
		end
	end
endmodule

@@ rtl/asc_fold.sv @@
// ----------------------------------------------------------------------------
// asc_fold
// Finish the mirror fold from the period remainder, pick the result by edge
// mode and hold it in the output register.
// ----------------------------------------------------------------------------
module asc_fold #(
	parameter int COORD_WIDTH = asc_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [COORD_WIDTH:0]          rem_x,
	input  logic [COORD_WIDTH:0]          rem_y,
	input  logic                          out_any,
	input  logic                          tneg_x,
	input  logic                          tneg_y,
	input  logic signed [COORD_WIDTH-1:0] sel_x,
	input  logic signed [COORD_WIDTH-1:0] sel_y,
	input  logic signed [COORD_WIDTH-1:0] min_x,
	input  logic signed [COORD_WIDTH-1:0] min_y,
	input  logic [COORD_WIDTH-1:0]        rng_x,
	input  logic [COORD_WIDTH-1:0]        rng_y,
	input  logic                          rng_pos_x,
	input  logic                          rng_pos_y,
	input  logic [COORD_WIDTH:0]          per_x,
	input  logic [COORD_WIDTH:0]          per_y,
	input  logic [1:0]                    mode,
	output logic                          valid_q,
	output logic signed [COORD_WIDTH-1:0] src_x_q,
	output logic signed [COORD_WIDTH-1:0] src_y_q,
	output logic                          outside_q
);
	localparam int W = COORD_WIDTH;

	logic [W:0]          l1_x, l1_y, l2_x, l2_y;
	logic signed [W+1:0] a_x, a_y;
	logic signed [W-1:0] m_x, m_y;

	// non-negative remainder, reflect the upper half, rebase on the minimum
	always_comb begin
		l1_x = (tneg_x && (rem_x != '0)) ? per_x - rem_x : rem_x;
		l1_y = (tneg_y && (rem_y != '0)) ? per_y - rem_y : rem_y;
		l2_x = (l1_x > {1'b0, rng_x}) ? per_x - l1_x : l1_x;
		l2_y = (l1_y > {1'b0, rng_y}) ? per_y - l1_y : l1_y;
		a_x  = (W+2)'(min_x) + $signed({1'b0, l2_x});
		a_y  = (W+2)'(min_y) + $signed({1'b0, l2_y});
		m_x  = rng_pos_x ? a_x[W-1:0] : min_x;
		m_y  = rng_pos_y ? a_y[W-1:0] : min_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	// select by edge mode
	always_ff @(posedge clk) begin
		if (adv) begin
			if (out_any && (mode == asc_pkg::MODE_MIRROR)) begin
				src_x_q   <= m_x;
				src_y_q   <= m_y;
				outside_q <= 1'b0;
			end else if (out_any && (mode != asc_pkg::MODE_CLAMP)) begin
				src_x_q   <= '0;
				src_y_q   <= '0;
				outside_q <= 1'b1;
			end else begin
				src_x_q   <= sel_x;
				src_y_q   <= sel_y;
				outside_q <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/affine_sample_coordinate_mapper.sv @@
// ----------------------------------------------------------------------------
// affine_sample_coordinate_mapper
// Inverse affine mapping of destination positions to source sample positions
// with zero, clamp or mirror handling at the domain edges.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one destination position (dest_x, dest_y) per transfer;
//   out_ch returns the source position (src_x, src_y) and the outside flag,
//   one result per input, in order.
//   Throughput is one transfer per cycle unless the receiver stalls. The pipeline
//   has three front stages (shift, rotate, magnitude), one stage per quotient
//   bit of the scale divider (COORD_WIDTH+17), two placement stages, one stage
//   per bit of the fold remainder divider (COORD_WIDTH), and the output
//   register.
//   The whole pipeline advances together; when the receiver stalls with a
//   result in the output register, every stage holds and in_ch.ready drops.
//   Configuration registers are written through cfg_wr_en/cfg_wr_index/
//   cfg_wr_data while no transfer is in flight.
//   Reset clears every valid bit and loads the register defaults: identity
//   rotation, unit scales, zero offset and bounds, zero edge mode.
// ----------------------------------------------------------------------------
module affine_sample_coordinate_mapper #(
	parameter int COORD_WIDTH = asc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	asc_in_if.sink                              in_ch,
	asc_out_if.source                           out_ch,
	input  logic                                cfg_wr_en,
	input  logic [asc_pkg::CFG_INDEX_W-1:0]     cfg_wr_index,
	input  logic [asc_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
	localparam int W  = COORD_WIDTH;
	localparam int NW = W + 17;

	logic signed [W-1:0] min_x, min_y, max_x, max_y, off_x, off_y, cen_x, cen_y;
	logic [W-1:0]        rng_x, rng_y;
	logic                rng_pos_x, rng_pos_y;
	logic [W:0]          per_x, per_y;
	logic signed [15:0]  cos_v, sin_v;
	logic [31:0]         scl_x, scl_y;
	logic [1:0]          mode;

	logic                adv;
	logic                f_valid, f_neg_x, f_neg_y;
	logic [NW-1:0]       f_mag_x, f_mag_y;
	logic                d_valid, d_neg_x, d_neg_y;
	logic [NW-1:0]       d_quo_x, d_quo_y;
	logic [31:0]         d_rem_x, d_rem_y;
	logic                p_valid, p_any, p_tneg_x, p_tneg_y;
	logic [W-1:0]        p_abs_x, p_abs_y;
	logic signed [W-1:0] p_sel_x, p_sel_y;
	logic                m_valid;
	logic [W-1:0]        m_quo_x, m_quo_y;
	logic [W:0]          m_rem_x, m_rem_y;
	logic [W+1:0]        m_side_x;
	logic [W:0]          m_side_y;

	// advance the whole pipeline unless a result is waiting on the receiver
	assign adv         = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	asc_cfg #(.COORD_WIDTH(W)) u_cfg (
		.clk(clk), .arst_n(arst_n),
		.wr_en(cfg_wr_en), .wr_index(cfg_wr_index), .wr_data(cfg_wr_data),
		.min_x(min_x), .min_y(min_y), .max_x(max_x), .max_y(max_y),
		.off_x(off_x), .off_y(off_y), .cen_x(cen_x), .cen_y(cen_y),
		.rng_x(rng_x), .rng_y(rng_y), .rng_pos_x(rng_pos_x), .rng_pos_y(rng_pos_y),
		.per_x(per_x), .per_y(per_y), .cos_v(cos_v), .sin_v(sin_v),
		.scl_x(scl_x), .scl_y(scl_y), .mode(mode)
	);

	asc_front #(.COORD_WIDTH(W)) u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(in_ch.valid), .dest_x(in_ch.dest_x), .dest_y(in_ch.dest_y),
		.cen_x(cen_x), .cen_y(cen_y), .off_x(off_x), .off_y(off_y),
		.cos_v(cos_v), .sin_v(sin_v),
		.valid_s3(f_valid), .mag_x_s3(f_mag_x), .mag_y_s3(f_mag_y),
		.neg_x_s3(f_neg_x), .neg_y_s3(f_neg_y)
	);

	// scale division, one lane per axis
	asc_div #(.NUM_W(NW), .DIV_W(32), .SIDE_W(1)) u_div_scl_x (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(f_valid), .in_num(f_mag_x), .divisor(scl_x), .in_side(f_neg_x),
		.out_valid(d_valid), .out_quo(d_quo_x), .out_rem(d_rem_x), .out_side(d_neg_x)
	);

	asc_div #(.NUM_W(NW), .DIV_W(32), .SIDE_W(1)) u_div_scl_y (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(f_valid), .in_num(f_mag_y), .divisor(scl_y), .in_side(f_neg_y),
		.out_valid(), .out_quo(d_quo_y), .out_rem(d_rem_y), .out_side(d_neg_y)
	);

	asc_place #(.COORD_WIDTH(W)) u_place (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(d_valid), .quo_x(d_quo_x), .quo_y(d_quo_y),
		.neg_x(d_neg_x), .neg_y(d_neg_y),
		.cen_x(cen_x), .cen_y(cen_y),
		.min_x(min_x), .min_y(min_y), .max_x(max_x), .max_y(max_y),
		.valid_s5(p_valid), .out_any_s5(p_any),
		.abs_x_s5(p_abs_x), .abs_y_s5(p_abs_y),
		.tneg_x_s5(p_tneg_x), .tneg_y_s5(p_tneg_y),
		.sel_x_s5(p_sel_x), .sel_y_s5(p_sel_y)
	);

	// fold remainder, one lane per axis
	asc_div #(.NUM_W(W), .DIV_W(W+1), .SIDE_W(W+2)) u_div_fold_x (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(p_valid), .in_num(p_abs_x), .divisor(per_x),
		.in_side({p_any, p_tneg_x, p_sel_x}),
		.out_valid(m_valid), .out_quo(m_quo_x), .out_rem(m_rem_x), .out_side(m_side_x)
	);

	asc_div #(.NUM_W(W), .DIV_W(W+1), .SIDE_W(W+1)) u_div_fold_y (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(p_valid), .in_num(p_abs_y), .divisor(per_y),
		.in_side({p_tneg_y, p_sel_y}),
		.out_valid(), .out_quo(m_quo_y), .out_rem(m_rem_y), .out_side(m_side_y)
	);

	asc_fold #(.COORD_WIDTH(W)) u_fold (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(m_valid), .rem_x(m_rem_x), .rem_y(m_rem_y),
		.out_any(m_side_x[W+1]), .tneg_x(m_side_x[W]), .tneg_y(m_side_y[W]),
		.sel_x(m_side_x[W-1:0]), .sel_y(m_side_y[W-1:0]),
		.min_x(min_x), .min_y(min_y), .rng_x(rng_x), .rng_y(rng_y),
		.rng_pos_x(rng_pos_x), .rng_pos_y(rng_pos_y),
		.per_x(per_x), .per_y(per_y), .mode(mode),
		.valid_q(out_ch.valid), .src_x_q(out_ch.src_x), .src_y_q(out_ch.src_y),
		.outside_q(out_ch.outside)
	);

	// a flagged result carries a zero position
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.outside |-> out_ch.src_x == '0 && out_ch.src_y == '0)
		else $error("outside result with nonzero position");

	// clamp and mirror modes never flag a result
	a_outside_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.outside |->
			mode != asc_pkg::MODE_CLAMP && mode != asc_pkg::MODE_MIRROR)
		else $error("outside flag raised in clamp or mirror mode");

	// clamped x stays within well-ordered bounds
	a_clamp_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && mode == asc_pkg::MODE_CLAMP && min_x <= max_x |->
			out_ch.src_x >= min_x && out_ch.src_x <= max_x)
		else $error("clamped x outside bounds");

	// folded y stays within a nondegenerate range
	a_mirror_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && mode == asc_pkg::MODE_MIRROR && rng_pos_y |->
			out_ch.src_y >= min_y && out_ch.src_y <= max_y)
		else $error("folded y outside bounds");

	// unused divider outputs: quotients of the fold and remainders of the scale
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(d_rem_x) && $stable(d_rem_y) && $stable(m_quo_x) && $stable(m_quo_y))
		else $error("pipeline moved while stalled");
endmodule
